// ===== hdl/rme_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix to Euler angles: shared package
// Widths, angle constants, the arctangent table and the small helper
// functions used by the square root and CORDIC cells and the top level.
// ----------------------------------------------------------------------------
package rme_pkg;

  localparam int CORDIC_STAGES = 16;              // range 8 .. 24
  localparam int SQ_STEPS      = 15;              // one result bit per cell
  localparam int LATENCY       = SQ_STEPS + CORDIC_STAGES + 4;

  localparam int XW = 34;                         // CORDIC x/y width
  localparam int ZW = 28;                         // CORDIC angle width

  localparam logic signed [ZW-1:0] HALF_PI_Z   = 28'sd26353589;
  localparam logic signed [17:0]   PI_Q13      = 18'sd25736;
  localparam logic signed [15:0]   HALF_PI_Q13 = 16'sd12868;
  localparam logic signed [15:0]   ONE_Q14     = 16'sd16384;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } rme_vec_t;

  typedef struct packed {
    logic [28:0] v;
    logic [29:0] r;
  } rme_root_t;

  // round(atan(2^-i) * 2^24)
  function automatic logic signed [ZW-1:0] atan_val(input logic [4:0] idx);
    logic signed [ZW-1:0] a;
    case (idx)
      5'd0:    a = 28'sd13176795;
      5'd1:    a = 28'sd7778716;
      5'd2:    a = 28'sd4110060;
      5'd3:    a = 28'sd2086331;
      5'd4:    a = 28'sd1047214;
      5'd5:    a = 28'sd524117;
      5'd6:    a = 28'sd262123;
      5'd7:    a = 28'sd131069;
      5'd8:    a = 28'sd65536;
      5'd9:    a = 28'sd32768;
      5'd10:   a = 28'sd16384;
      5'd11:   a = 28'sd8192;
      5'd12:   a = 28'sd4096;
      5'd13:   a = 28'sd2048;
      5'd14:   a = 28'sd1024;
      5'd15:   a = 28'sd512;
      5'd16:   a = 28'sd256;
      5'd17:   a = 28'sd128;
      5'd18:   a = 28'sd64;
      5'd19:   a = 28'sd32;
      5'd20:   a = 28'sd16;
      5'd21:   a = 28'sd8;
      5'd22:   a = 28'sd4;
      5'd23:   a = 28'sd2;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Moves the vector into the right half plane and scales it by 2^12.
  function automatic rme_vec_t pre_rotate(input logic signed [17:0] y,
                                          input logic signed [17:0] x);
    rme_vec_t             o;
    logic signed [XW-1:0] xe;
    logic signed [XW-1:0] ye;
    xe = XW'(x);
    ye = XW'(y);
    o.z    = '0;
    o.zero = (x == 18'sd0) && (y == 18'sd0);
    if (x < 0) begin
      if (y >= 0) begin
        o.x = ye;
        o.y = -xe;
        o.z = HALF_PI_Z;
      end else begin
        o.x = -ye;
        o.y = xe;
        o.z = -HALF_PI_Z;
      end
    end else begin
      o.x = xe;
      o.y = ye;
    end
    o.x = o.x <<< 12;
    o.y = o.y <<< 12;
    return o;
  endfunction

  // Rounds the accumulated angle to Q3.13 and clamps it to plus or minus pi.
  function automatic logic signed [15:0] to_angle(input rme_vec_t d);
    logic signed [ZW:0] zr;
    logic signed [17:0] a;
    zr = (ZW+1)'(d.z) + 29'sd1024;
    a  = 18'(zr >>> 11);
    if (d.zero)          a = '0;
    else if (a > PI_Q13) a = PI_Q13;
    else if (a < -PI_Q13) a = -PI_Q13;
    return a[15:0];
  endfunction

endpackage

// ===== hdl/rotation_matrix_to_euler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix to Euler angles (ZYX) core
// Converts a 3x3 Q2.14 rotation matrix to roll and yaw in Q3.13 and pitch in Q2.13.
//
//   channel | ports                         | transaction when
//   --------+-------------------------------+---------------------------
//   input   | start, busy, in_elem_*        | start high and busy low
//   result  | out_valid, out_*_angle        | out_valid high (one cycle)
//   config  | cfg_valid, cfg_ready, cfg_*   | cfg_valid and cfg_ready high
//
// One transaction is taken in every cycle; busy is always low.
// Each result follows its input transaction through the 15-cell square root
// chain followed by the CORDIC cell chain plus four register stages.
// Reset (rst_n low, synchronous) empties the pipeline and sets lock_margin
// to 8. The receiver cannot stall, so nothing ever holds up the chain.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_core import rme_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_elem_00,
  input  logic signed [15:0] in_elem_01,
  input  logic signed [15:0] in_elem_02,
  input  logic signed [15:0] in_elem_10,
  input  logic signed [15:0] in_elem_11,
  input  logic signed [15:0] in_elem_12,
  input  logic signed [15:0] in_elem_20,
  input  logic signed [15:0] in_elem_21,
  input  logic signed [15:0] in_elem_22,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_lock_margin,
  output logic               out_valid,
  output logic signed [15:0] out_roll_angle,
  output logic signed [14:0] out_pitch_angle,
  output logic signed [15:0] out_yaw_angle
);

  // Matrix elements and the sine of the pitch travel alongside the root chain.
  typedef struct packed {
    logic signed [15:0] s;
    logic signed [15:0] e00;
    logic signed [15:0] e01;
    logic signed [15:0] e02;
    logic signed [15:0] e10;
    logic signed [15:0] e11;
    logic signed [15:0] e12;
    logic signed [15:0] e21;
    logic signed [15:0] e22;
  } rme_side_t;

  localparam int NVAL = LATENCY - 1;

  logic              accept;
  logic [NVAL-1:0]   vld_r;
  logic [7:0]        margin_r;
  rme_side_t         a_r;
  rme_side_t         a_nxt;
  rme_side_t         b_r;
  logic [28:0]       v_r;
  logic signed [16:0] neg20;
  rme_side_t         side_r [SQ_STEPS];
  rme_root_t         sq_in  [SQ_STEPS];
  rme_root_t         sq_out [SQ_STEPS];
  rme_vec_t          cd_in  [4][CORDIC_STAGES];
  rme_vec_t          cd_out [4][CORDIC_STAGES];
  rme_vec_t          pre_r  [4];
  logic signed [15:0] pitch_raw;
  logic signed [15:0] pitch;
  logic signed [16:0] dp;
  logic signed [16:0] dm;
  logic               lock;
  logic signed [15:0] roll_nxt;
  logic signed [15:0] yaw_nxt;
  logic signed [17:0] yl_y;
  logic signed [17:0] yl_x;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= 8'd8;
    end else if (cfg_valid && cfg_ready) begin
      margin_r <= cfg_lock_margin;
    end
  end

  // Valid bits for every register stage up to the output.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      vld_r     <= {vld_r[NVAL-2:0], accept};
      out_valid <= vld_r[NVAL-1];
    end
  end

  // Stage A: capture the matrix and saturate minus e20 to [-1, 1].
  always_comb begin
    neg20     = -17'(in_elem_20);
    a_nxt.e00 = in_elem_00;
    a_nxt.e01 = in_elem_01;
    a_nxt.e02 = in_elem_02;
    a_nxt.e10 = in_elem_10;
    a_nxt.e11 = in_elem_11;
    a_nxt.e12 = in_elem_12;
    a_nxt.e21 = in_elem_21;
    a_nxt.e22 = in_elem_22;
    if (neg20 > 17'(ONE_Q14))       a_nxt.s = ONE_Q14;
    else if (neg20 < -17'(ONE_Q14)) a_nxt.s = -ONE_Q14;
    else                             a_nxt.s = neg20[15:0];
  end

  // Stage B: the radicand 1 - s*s in Q1.28.
  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= a_r;
    v_r <= 29'(29'sh1000_0000 - 29'(32'(a_r.s) * 32'(a_r.s)));
  end

  // Square root chain: one cell per result bit; the side data rides along.
  genvar k;
  generate
    for (k = 0; k < SQ_STEPS; k++) begin : g_sq
      if (k == 0) begin : g_first
        assign sq_in[k] = '{v: v_r, r: '0};
        always_ff @(posedge clk) side_r[k] <= b_r;
      end else begin : g_next
        assign sq_in[k] = sq_out[k-1];
        always_ff @(posedge clk) side_r[k] <= side_r[k-1];
      end
      rme_sqrt_cell u_sq (
        .clk  (clk),
        .step (4'(k)),
        .d    (sq_in[k]),
        .q_r  (sq_out[k])
      );
    end
  endgenerate

  // Pre-rotation stage for the four arctangent lanes:
  // 0 pitch, 1 roll, 2 yaw, 3 yaw under gimbal lock.
  assign yl_y = 18'(side_r[SQ_STEPS-1].e12) - 18'(side_r[SQ_STEPS-1].e01);
  assign yl_x = 18'(side_r[SQ_STEPS-1].e02) + 18'(side_r[SQ_STEPS-1].e11);

  always_ff @(posedge clk) begin
    pre_r[0] <= pre_rotate(18'(side_r[SQ_STEPS-1].s),
                           18'(sq_out[SQ_STEPS-1].r[15:0]));
    pre_r[1] <= pre_rotate(18'(side_r[SQ_STEPS-1].e21), 18'(side_r[SQ_STEPS-1].e22));
    pre_r[2] <= pre_rotate(18'(side_r[SQ_STEPS-1].e10), 18'(side_r[SQ_STEPS-1].e00));
    pre_r[3] <= pre_rotate(yl_y, yl_x);
  end

  // CORDIC chains, one cell per micro-rotation in each lane.
  genvar ln, st;
  generate
    for (ln = 0; ln < 4; ln++) begin : g_lane
      for (st = 0; st < CORDIC_STAGES; st++) begin : g_st
        if (st == 0) begin : g_first
          assign cd_in[ln][st] = pre_r[ln];
        end else begin : g_next
          assign cd_in[ln][st] = cd_out[ln][st-1];
        end
        rme_cordic_cell u_cd (
          .clk   (clk),
          .stage (5'(st)),
          .d     (cd_in[ln][st]),
          .q_r   (cd_out[ln][st])
        );
      end
    end
  endgenerate

  // Output stage: round, clamp, gimbal lock test and selection.
  always_comb begin
    pitch_raw = to_angle(cd_out[0][CORDIC_STAGES-1]);
    if (pitch_raw > HALF_PI_Q13)       pitch = HALF_PI_Q13;
    else if (pitch_raw < -HALF_PI_Q13) pitch = -HALF_PI_Q13;
    else                               pitch = pitch_raw;
    dp = 17'(pitch) - 17'(HALF_PI_Q13);
    dm = 17'(pitch) + 17'(HALF_PI_Q13);
    if (dp < 0) dp = -dp;
    if (dm < 0) dm = -dm;
    lock = (dp < $signed({9'd0, margin_r})) || (dm < $signed({9'd0, margin_r}));
    if (lock) begin
      roll_nxt = '0;
      yaw_nxt  = to_angle(cd_out[3][CORDIC_STAGES-1]);
    end else begin
      roll_nxt = to_angle(cd_out[1][CORDIC_STAGES-1]);
      yaw_nxt  = to_angle(cd_out[2][CORDIC_STAGES-1]);
    end
  end

  always_ff @(posedge clk) begin
    out_roll_angle  <= roll_nxt;
    out_pitch_angle <= pitch[14:0];
    out_yaw_angle   <= yaw_nxt;
  end

  // Every result strobe traces back to one input transaction.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without matching input transaction");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pitch_angle <= 15'sd12868 && out_pitch_angle >= -15'sd12868))
    else $error("pitch outside half pi");

  a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_roll_angle <= 16'sd25736 && out_roll_angle >= -16'sd25736))
    else $error("roll outside pi");

  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_yaw_angle <= 16'sd25736 && out_yaw_angle >= -16'sd25736))
    else $error("yaw outside pi");

endmodule

// ===== hdl/rme_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square root cell
// One step of the digit-by-digit integer square root; one result bit per cell.
// ----------------------------------------------------------------------------
module rme_sqrt_cell import rme_pkg::*; (
  input  logic      clk,
  input  logic [3:0] step,
  input  rme_root_t d,
  output rme_root_t q_r
);

  rme_root_t   q_nxt;
  logic [29:0] b;
  logic [30:0] rb;

  always_comb begin
    b  = 30'd1 << (5'd28 - {step, 1'b0});
    rb = {1'b0, d.r} + {1'b0, b};
    if ({2'b00, d.v} >= rb) begin
      q_nxt.v = 29'({2'b00, d.v} - rb);
      q_nxt.r = (d.r >> 1) + b;
    end else begin
      q_nxt.v = d.v;
      q_nxt.r = d.r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

endmodule

// ===== hdl/rme_cordic_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CORDIC vectoring cell
// One micro-rotation toward y = 0 with angle accumulation, registered.
// ----------------------------------------------------------------------------
module rme_cordic_cell import rme_pkg::*; (
  input  logic       clk,
  input  logic [4:0] stage,
  input  rme_vec_t   d,
  output rme_vec_t   q_r
);

  rme_vec_t             q_nxt;
  logic signed [XW-1:0] xi;
  logic signed [XW-1:0] yi;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;

  always_comb begin
    xi = d.x;
    yi = d.y;
    xs = xi >>> stage;
    ys = yi >>> stage;
    q_nxt.zero = d.zero;
    if (yi >= 0) begin
      q_nxt.x = xi + ys;
      q_nxt.y = yi - xs;
      q_nxt.z = d.z + atan_val(stage);
    end else begin
      q_nxt.x = xi - ys;
      q_nxt.y = yi + xs;
      q_nxt.z = d.z - atan_val(stage);
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the rotation matrix to Euler angles core
// Streams 3x3 Q2.14 matrices into the core and compares every roll, pitch
// and yaw result against a bit-accurate CORDIC model kept in this file.
// The runs cover directed corner matrices, several gimbal lock margins and
// random traffic with different amounts of sender idling.
// ----------------------------------------------------------------------------
module tb_top;
  import rme_pkg::*;

  // One expected result: the three angles at the core's output widths.
  typedef struct {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
  } euler_t;

  // One input matrix, row-major, elements as they appear on the ports.
  typedef logic signed [15:0] matrix_t [9];

  localparam int CYCLE_LIMIT = 200000;

  // round(atan(2^-i) * 2^24), indexed by the CORDIC stage.
  localparam longint ARCTAN_STEP [24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [15:0] in_elem_00, in_elem_01, in_elem_02;
  logic signed [15:0] in_elem_10, in_elem_11, in_elem_12;
  logic signed [15:0] in_elem_20, in_elem_21, in_elem_22;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [7:0]         cfg_lock_margin;
  logic               out_valid;
  logic signed [15:0] out_roll_angle;
  logic signed [14:0] out_pitch_angle;
  logic signed [15:0] out_yaw_angle;

  // The model's copy of the lock margin register.
  longint  margin_shadow;
  euler_t  pending_angles [$];
  int      mismatch_count;
  int      cycle_count;

  rotation_matrix_to_euler_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_elem_00      (in_elem_00),
    .in_elem_01      (in_elem_01),
    .in_elem_02      (in_elem_02),
    .in_elem_10      (in_elem_10),
    .in_elem_11      (in_elem_11),
    .in_elem_12      (in_elem_12),
    .in_elem_20      (in_elem_20),
    .in_elem_21      (in_elem_21),
    .in_elem_22      (in_elem_22),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_lock_margin (cfg_lock_margin),
    .out_valid       (out_valid),
    .out_roll_angle  (out_roll_angle),
    .out_pitch_angle (out_pitch_angle),
    .out_yaw_angle   (out_yaw_angle)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Vectoring CORDIC arctangent, Q3.13 result. A left half plane vector is
  // first turned by a quarter turn; arithmetic shifts round toward minus
  // infinity, exactly as the hardware does.
  function automatic longint cordic_arctan(longint y, longint x);
    longint z;
    longint t;
    longint xs;
    longint ys;
    longint r;
    z = 0;
    if (x == 0 && y == 0) begin
      return 0;
    end
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 26353589;
      end else begin
        t = x; x = -y; y = t; z = -26353589;
      end
    end
    x = x * 4096;
    y = y * 4096;
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + ARCTAN_STEP[i];
      end else begin
        x = x - ys; y = y + xs; z = z - ARCTAN_STEP[i];
      end
    end
    r = (z + 1024) >>> 11;
    if (r > 25736) r = 25736;
    if (r < -25736) r = -25736;
    return r;
  endfunction

  // Bitwise integer square root, floor.
  function automatic longint floor_root(longint v);
    longint r;
    longint b;
    r = 0;
    b = 64'd1 << 30;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Expected angles for one matrix under the current lock margin.
  function automatic euler_t predict_angles(matrix_t m);
    euler_t a;
    longint s;
    longint c;
    longint p;
    longint dp;
    longint dm;
    s = -longint'(m[6]);
    if (s > 16384) s = 16384;
    if (s < -16384) s = -16384;
    c = floor_root(268435456 - s * s);
    p = cordic_arctan(s, c);
    if (p > 12868) p = 12868;
    if (p < -12868) p = -12868;
    dp = p - 12868;
    if (dp < 0) dp = -dp;
    dm = p + 12868;
    if (dm < 0) dm = -dm;
    a.pitch = 15'(p);
    if (dp < margin_shadow || dm < margin_shadow) begin
      // Gimbal lock: roll is dropped and yaw comes from the off-diagonal terms.
      a.roll = '0;
      a.yaw  = 16'(cordic_arctan(longint'(m[5]) - longint'(m[1]),
                                 longint'(m[2]) + longint'(m[4])));
    end else begin
      a.roll = 16'(cordic_arctan(longint'(m[7]), longint'(m[8])));
      a.yaw  = 16'(cordic_arctan(longint'(m[3]), longint'(m[0])));
    end
    return a;
  endfunction

  // Every output-valid cycle carries one result; compare it with the oldest
  // expectation. Outputs are sampled at the edge that ends the strobe cycle.
  always @(posedge clk) begin
    euler_t e;
    if (rst_n && out_valid) begin
      if (pending_angles.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result: roll %0d pitch %0d yaw %0d",
                   out_roll_angle, out_pitch_angle, out_yaw_angle);
        end
      end else begin
        e = pending_angles.pop_front();
        if (e.roll !== out_roll_angle || e.pitch !== out_pitch_angle ||
            e.yaw !== out_yaw_angle) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("angle mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                     e.roll, e.pitch, e.yaw,
                     out_roll_angle, out_pitch_angle, out_yaw_angle);
          end
        end
      end
    end
  end

  // Watchdog against a hung pipeline or handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Sends one matrix transaction. In each cycle the sender idles with
  // probability idle_pct percent before it raises start. Start is left high
  // after the transaction so back-to-back matrices stream without a gap.
  task automatic send_matrix(matrix_t m, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    in_elem_00 <= m[0]; in_elem_01 <= m[1]; in_elem_02 <= m[2];
    in_elem_10 <= m[3]; in_elem_11 <= m[4]; in_elem_12 <= m[5];
    in_elem_20 <= m[6]; in_elem_21 <= m[7]; in_elem_22 <= m[8];
    do @(posedge clk); while (busy);
    pending_angles.push_back(predict_angles(m));
  endtask

  // Waits until every outstanding result has arrived, then lets the pipeline run empty.
  task automatic drain_pipeline();
    start <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Writes the lock margin while the core is idle.
  task automatic write_margin(logic [7:0] value);
    drain_pipeline();
    cfg_valid       <= 1'b1;
    cfg_lock_margin <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid     <= 1'b0;
    margin_shadow = value;
  endtask

  // Random matrix. Most draws stay inside the Q2.14 range, a share sits
  // near gimbal lock, some use the full 16-bit range and some are tiny.
  function automatic matrix_t random_matrix();
    matrix_t m;
    int      kind;
    kind = $urandom_range(99);
    for (int i = 0; i < 9; i++) begin
      if (kind < 40) m[i] = 16'($urandom_range(32768) - 16384);
      else if (kind < 65) m[i] = 16'($urandom_range(4000) - 2000);
      else if (kind < 85) m[i] = 16'($urandom);
      else m[i] = 16'($urandom_range(6) - 3);
    end
    if (kind >= 40 && kind < 65) begin
      // Pitch close to plus or minus pi/2, sometimes past saturation.
      m[6] = 16'($urandom_range(16384, 16360));
      if ($urandom_range(3) == 0) m[6] = 16'($urandom_range(32767, 16385));
      if ($urandom_range(1) == 0) m[6] = -m[6];
    end
    return m;
  endfunction

  task automatic test_directed();
    matrix_t m;
    m = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};     // identity
    send_matrix(m, 0);
    m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                 // all zero vectors
    send_matrix(m, 0);
    m = '{0, 0, 16384, 0, 16384, 0, -16384, 0, 0};    // pitch +pi/2
    send_matrix(m, 0);
    m = '{0, 0, -16384, 0, 16384, 0, 16384, 0, 0};    // pitch -pi/2
    send_matrix(m, 0);
    m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384};  // negative x both ways
    send_matrix(m, 0);
    m = '{-16384, 0, 0, -1, 0, 0, 0, -1, -16384};
    send_matrix(m, 0);
    m = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
    send_matrix(m, 0);
    m = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
    send_matrix(m, 0);
    m = '{-16384, 32767, -32768, 16384, 32767, -32768, 0, 16384, -16384};
    send_matrix(m, 0);
    m = '{16384, -16384, 16384, -16384, 16384, -16384, 16384, -16384, 16384};
    send_matrix(m, 0);
    m = '{1, 0, 0, 0, 1, 0, 16383, 0, -1};            // near lock, inside it only for a wide margin
    send_matrix(m, 0);
    m = '{0, 1, 0, -1, 0, 1, -16376, 1, 0};
    send_matrix(m, 0);
    m = '{11585, -11585, 0, 11585, 11585, 0, 0, 0, 16384};  // 45 degree yaw
    send_matrix(m, 0);
    m = '{0, 16384, 0, -16384, 0, 0, 0, 0, 16384};
    send_matrix(m, 0);
  endtask

  // Corner and random matrices again under the margin extremes, a margin of one and a random value.
  task automatic test_margin_settings();
    logic [7:0] margins [4];
    margins = '{8'd0, 8'd255, 8'd1, 8'($urandom_range(2, 254))};
    foreach (margins[k]) begin
      write_margin(margins[k]);
      test_directed();
      repeat (20) send_matrix(random_matrix(), 10);
    end
  endtask

  task automatic test_random_phase(int idle_pct, int count);
    repeat (count) send_matrix(random_matrix(), idle_pct);
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    cfg_valid       = 1'b0;
    cfg_lock_margin = '0;
    in_elem_00 = '0; in_elem_01 = '0; in_elem_02 = '0;
    in_elem_10 = '0; in_elem_11 = '0; in_elem_12 = '0;
    in_elem_20 = '0; in_elem_21 = '0; in_elem_22 = '0;
    margin_shadow  = 8;
    mismatch_count = 0;
    cycle_count    = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The reset margin is checked first, before any register write.
    test_directed();
    test_margin_settings();
    write_margin(8'd8);
    test_random_phase(23, 300);
    write_margin(8'($urandom_range(255)));
    test_random_phase(59, 300);
    write_margin(8'd200);
    test_random_phase(0, 300);

    drain_pipeline();
    if (mismatch_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== rotation_matrix_to_euler_core.f =====
hdl/rme_pkg.sv
hdl/rme_sqrt_cell.sv
hdl/rme_cordic_cell.sv
hdl/rotation_matrix_to_euler_core.sv
tb/tb_top.sv
